[hdl/vfs_pkg.sv]
package vfs_pkg;

	// Fixed field widths of the stream and result channels
	localparam int BYTE_BITS   = 8;
	localparam int FIELD_BITS  = 24;
	localparam int KIND_BITS   = 2;
	localparam int TIB_BITS    = 5;
	localparam int FILL_BITS   = 3;
	localparam int WINDOW_BITS = 32;

	// Start code detection
	localparam logic [2:0]            WINDOW_FULL  = 3'd4;
	localparam logic [23:0]           START_PREFIX = 24'h000001;
	localparam logic [BYTE_BITS-1:0]  VOP_CODE     = 8'hB6;

	// Frame kinds as reported
	localparam logic [KIND_BITS-1:0] FRAME_KIND_I  = 2'd0;
	localparam logic [KIND_BITS-1:0] FRAME_KIND_P  = 2'd1;
	localparam logic [KIND_BITS-1:0] FRAME_KIND_B  = 2'd2;
	// coding type code for sprite VOPs, reported as predicted
	localparam logic [KIND_BITS-1:0] CODING_SPRITE = 2'd3;

	// Byte classified by the front end
	typedef struct packed {
		logic [BYTE_BITS-1:0] data_byte;
		logic                 end_of_buffer;
		logic                 vop_hit;
	} vfs_item_t;

endpackage

[hdl/vfs_if.sv]
// Byte stream channel
interface vfs_stream_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_buffer;

	modport source(output valid, data_byte, end_of_buffer, input ready);
	modport sink(input valid, data_byte, end_of_buffer, output ready);
endinterface

// Frame result channel
interface vfs_frame_if;
	logic        valid;
	logic        ready;
	logic [23:0] frame_offset;
	logic [23:0] frame_length;
	logic [1:0]  frame_kind;
	logic        coded_flag;
	logic        header_short;
	logic        closes_buffer;

	modport source(output valid, frame_offset, frame_length, frame_kind, coded_flag,
		header_short, closes_buffer, input ready);
	modport sink(input valid, frame_offset, frame_length, frame_kind, coded_flag,
		header_short, closes_buffer, output ready);
endinterface

// Configuration write channel
interface vfs_cfg_if;
	logic       valid;
	logic       ready;
	logic [4:0] time_increment_bits;

	modport source(output valid, time_increment_bits, input ready);
	modport sink(input valid, time_increment_bits, output ready);
endinterface

[hdl/vfs_front.sv]
// Start code scanner: shifts bytes through the code window, tags VOP hits
module vfs_front #(
	parameter int OFFSET_BITS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	vfs_stream_if.sink             stream,
	input  logic                   q_full,
	output logic                   push,
	output vfs_pkg::vfs_item_t     item,
	output logic [OFFSET_BITS-1:0] position
);

	logic [vfs_pkg::WINDOW_BITS-1:0] window_q, window_next;
	logic [vfs_pkg::FILL_BITS-1:0]   fill_q, fill_next;
	logic [OFFSET_BITS-1:0]          pos_q;
	logic                            start_hit;

	assign stream.ready = !q_full;
	assign push         = stream.valid && !q_full;

	// window after this byte, and whether it holds a start code
	always_comb begin
		window_next = {window_q[vfs_pkg::WINDOW_BITS-vfs_pkg::BYTE_BITS-1:0], stream.data_byte};
		fill_next   = (fill_q < vfs_pkg::WINDOW_FULL) ? fill_q + 3'd1 : fill_q;
		start_hit   = (fill_next == vfs_pkg::WINDOW_FULL) && !stream.end_of_buffer &&
			(window_next[31:8] == vfs_pkg::START_PREFIX);
	end

	assign item.data_byte     = stream.data_byte;
	assign item.end_of_buffer = stream.end_of_buffer;
	assign item.vop_hit       = start_hit && (window_next[7:0] == vfs_pkg::VOP_CODE);
	assign position           = pos_q;

	// scanner state; buffer end returns it to reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			fill_q   <= '0;
			pos_q    <= '0;
		end else if (push) begin
			if (stream.end_of_buffer) begin
				window_q <= '0;
				fill_q   <= '0;
				pos_q    <= '0;
			end else begin
				// start codes do not overlap: refill from empty
				window_q <= start_hit ? '0 : window_next;
				fill_q   <= start_hit ? '0 : fill_next;
				pos_q    <= pos_q + OFFSET_BITS'(1);
			end
		end
	end

endmodule

[hdl/vfs_queue.sv]
// Two-entry queue between scanner and header parser
module vfs_queue #(
	parameter int WIDTH = 35
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	logic [WIDTH-1:0] slot_q [2];
	logic             wr_q, rd_q;
	logic [1:0]       count_q;

	assign full     = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign pop_data = slot_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	// pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[hdl/vfs_back.sv]
// Header parser and frame reporter
module vfs_back #(
	parameter int OFFSET_BITS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	vfs_cfg_if.sink                cfg,
	vfs_frame_if.source            frames,
	input  logic                   q_empty,
	output logic                   pop,
	input  vfs_pkg::vfs_item_t     item,
	input  logic [OFFSET_BITS-1:0] position
);

	typedef enum logic [2:0] {
		HDR_IDLE,
		HDR_TYPE_HI,
		HDR_TYPE_LO,
		HDR_MODULO,
		HDR_MARKER1,
		HDR_INCR,
		HDR_MARKER2,
		HDR_CODED
	} hdr_phase_t;

	typedef struct packed {
		hdr_phase_t                       phase;
		logic [vfs_pkg::TIB_BITS-1:0]     left;
		logic [vfs_pkg::KIND_BITS-1:0]    kind;
		logic                             coded;
	} hdr_t;

	logic [vfs_pkg::TIB_BITS-1:0] tib_q;
	logic                         open_q;
	logic [OFFSET_BITS-1:0]       offset_q;
	hdr_t                         hdr_q, hdr_next;

	logic                            out_valid_q;
	logic [vfs_pkg::FIELD_BITS-1:0]  out_offset_q, out_length_q;
	logic [vfs_pkg::KIND_BITS-1:0]   out_kind_q;
	logic                            out_coded_q, out_short_q, out_end_q;

	logic                           emit;
	logic                           shortened;
	logic [OFFSET_BITS-1:0]         start_pos, end_pos, length;
	logic [vfs_pkg::FIELD_BITS-1:0] offset_f, length_f;

	// one header bit
	function automatic hdr_t hdr_step(hdr_t h, logic b, logic [vfs_pkg::TIB_BITS-1:0] tib);
		hdr_t n;
		logic [vfs_pkg::KIND_BITS-1:0] t;
		n = h;
		t = {h.kind[1], b};
		case (h.phase)
			HDR_TYPE_HI: begin
				n.kind  = {b, 1'b0};
				n.phase = HDR_TYPE_LO;
			end
			HDR_TYPE_LO: begin
				n.kind  = (t == vfs_pkg::CODING_SPRITE) ? vfs_pkg::FRAME_KIND_P : t;
				n.phase = HDR_MODULO;
			end
			HDR_MODULO: begin
				if (!b) begin
					n.phase = HDR_MARKER1;
				end
			end
			HDR_MARKER1: begin
				if (tib == '0) begin
					n.phase = HDR_MARKER2;
				end else begin
					n.left  = tib;
					n.phase = HDR_INCR;
				end
			end
			HDR_INCR: begin
				n.left = h.left - 5'd1;
				if (h.left == 5'd1) begin
					n.phase = HDR_MARKER2;
				end
			end
			HDR_MARKER2: n.phase = HDR_CODED;
			HDR_CODED: begin
				n.coded = b;
				n.phase = HDR_IDLE;
			end
			default: n = h;
		endcase
		return n;
	endfunction

	assign cfg.ready = 1'b1;
	assign pop       = !q_empty && (!out_valid_q || frames.ready);

	// header bits of this byte, MSB first
	always_comb begin
		hdr_next = hdr_q;
		for (int i = vfs_pkg::BYTE_BITS - 1; i >= 0; i--) begin
			if (open_q && hdr_next.phase != HDR_IDLE) begin
				hdr_next = hdr_step(hdr_next, item.data_byte[i], tib_q);
			end
		end
	end

	// frame close: VOP code start or buffer end
	always_comb begin
		emit      = open_q && (item.end_of_buffer || item.vop_hit);
		shortened = (hdr_next.phase != HDR_IDLE);
		start_pos = position - OFFSET_BITS'(3);
		end_pos   = item.end_of_buffer ? position + OFFSET_BITS'(1) : start_pos;
		length    = end_pos - offset_q;
	end

	generate
		if (OFFSET_BITS >= vfs_pkg::FIELD_BITS) begin : g_trunc
			assign offset_f = offset_q[vfs_pkg::FIELD_BITS-1:0];
			assign length_f = length[vfs_pkg::FIELD_BITS-1:0];
		end else begin : g_ext
			assign offset_f = {{(vfs_pkg::FIELD_BITS-OFFSET_BITS){1'b0}}, offset_q};
			assign length_f = {{(vfs_pkg::FIELD_BITS-OFFSET_BITS){1'b0}}, length};
		end
	endgenerate

	// parser state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tib_q        <= '0;
			open_q       <= 1'b0;
			offset_q     <= '0;
			hdr_q        <= '{phase: HDR_IDLE, left: '0, kind: '0, coded: 1'b0};
			out_valid_q  <= 1'b0;
			out_offset_q <= '0;
			out_length_q <= '0;
			out_kind_q   <= '0;
			out_coded_q  <= 1'b0;
			out_short_q  <= 1'b0;
			out_end_q    <= 1'b0;
		end else begin
			if (cfg.valid) begin
				tib_q <= cfg.time_increment_bits;
			end
			if (frames.ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				if (emit) begin
					out_valid_q  <= 1'b1;
					out_offset_q <= offset_f;
					out_length_q <= length_f;
					out_kind_q   <= shortened ? vfs_pkg::FRAME_KIND_I : hdr_next.kind;
					out_coded_q  <= shortened ? 1'b0 : hdr_next.coded;
					out_short_q  <= shortened;
					out_end_q    <= item.end_of_buffer;
				end
				if (item.end_of_buffer) begin
					open_q   <= 1'b0;
					offset_q <= '0;
					hdr_q    <= '{phase: HDR_IDLE, left: '0, kind: '0, coded: 1'b0};
				end else if (item.vop_hit) begin
					open_q   <= 1'b1;
					offset_q <= start_pos;
					hdr_q    <= '{phase: HDR_TYPE_HI, left: '0, kind: '0, coded: 1'b0};
				end else begin
					hdr_q <= hdr_next;
				end
			end
		end
	end

	assign frames.valid         = out_valid_q;
	assign frames.frame_offset  = out_offset_q;
	assign frames.frame_length  = out_length_q;
	assign frames.frame_kind    = out_kind_q;
	assign frames.coded_flag    = out_coded_q;
	assign frames.header_short  = out_short_q;
	assign frames.closes_buffer = out_end_q;

endmodule

[hdl/vop_frame_splitter.sv]
// Channel  | Dir | Request
// ---------+-----+----------------------------------------------------------
// stream   | in  | one buffer byte, data_byte and end_of_buffer
// frames   | out | one closed frame: offset, length, kind, coded, short, end
// cfg      | in  | time_increment_bits write
//
// One byte is taken per cycle while the queue has room; the byte closing a
// frame is queued, then the parser reports it from the result register.
// The two-entry queue lets the scanner keep taking bytes while a result waits.
// arst_n clears all stream state and time_increment_bits to zero.
// A stalled result holds the parser; the scanner stalls once the queue fills.
module vop_frame_splitter #(
	parameter int OFFSET_BITS = 24
) (
	input  logic         clk,
	input  logic         arst_n,
	vfs_stream_if.sink   stream,
	vfs_frame_if.source  frames,
	vfs_cfg_if.sink      cfg
);

	localparam int ITEM_BITS  = $bits(vfs_pkg::vfs_item_t);
	localparam int ENTRY_BITS = ITEM_BITS + OFFSET_BITS;

	logic                   q_full, q_empty, push, pop;
	vfs_pkg::vfs_item_t     f_item, b_item;
	logic [OFFSET_BITS-1:0] f_pos, b_pos;
	logic [ENTRY_BITS-1:0]  q_out;

	vfs_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.stream   (stream),
		.q_full   (q_full),
		.push     (push),
		.item     (f_item),
		.position (f_pos)
	);

	vfs_queue #(.WIDTH(ENTRY_BITS)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({f_item, f_pos}),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (q_out),
		.empty     (q_empty)
	);

	assign b_item = q_out[ENTRY_BITS-1:OFFSET_BITS];
	assign b_pos  = q_out[OFFSET_BITS-1:0];

	vfs_back #(.OFFSET_BITS(OFFSET_BITS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.frames   (frames),
		.q_empty  (q_empty),
		.pop      (pop),
		.item     (b_item),
		.position (b_pos)
	);

endmodule
